// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the conversion unit.
// Depends on signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/ift_pkg.sv =====
// Types, codes and helper functions of the integer/float conversion unit.
// No dependencies; the stage modules and the top level import this package.
`default_nettype none

package ift_pkg;

  // Size codes of the source and destination fields.
  localparam logic [1:0] SIZE_B8  = 2'd0;
  localparam logic [1:0] SIZE_B16 = 2'd1;
  localparam logic [1:0] SIZE_B32 = 2'd2;
  localparam logic [1:0] SIZE_B64 = 2'd3;

  localparam int EXP_W = 13;

  localparam logic signed [EXP_W-1:0] S_BIAS   = 13'sd127;
  localparam logic signed [EXP_W-1:0] D_BIAS   = 13'sd1023;
  localparam logic signed [EXP_W-1:0] S_EMIN   = -13'sd126;
  localparam logic signed [EXP_W-1:0] S_EMAX   = 13'sd127;
  localparam logic signed [EXP_W-1:0] INT_EXP  = 13'sd63;

  // What the pipeline does with a transaction.
  typedef enum logic [1:0] {
    MODE_RAW,
    MODE_TO_S,
    MODE_TO_D,
    MODE_TO_I
  } mode_t;

  // Class of the unpacked source value.
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_FIN,
    CLS_INF,
    CLS_NAN
  } cls_t;

  // Value as it travels down the pipe: sig * 2^(exp - 63).
  typedef struct packed {
    mode_t                   mode;
    cls_t                    cls;
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [63:0]             sig;
    logic [1:0]              dsz;
  } stage_t;

  // All-ones mask of an 8, 16, 32 or 64 bit field.
  function automatic logic [63:0] size_mask(input logic [1:0] s);
    logic [63:0] m;
    case (s)
      SIZE_B8:  m = 64'h0000_0000_0000_00FF;
      SIZE_B16: m = 64'h0000_0000_0000_FFFF;
      SIZE_B32: m = 64'h0000_0000_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/ift_if.sv =====
// Valid/ready channel interfaces of the conversion unit.
// No dependencies.
`default_nettype none

// Source side: one conversion request per transaction.
interface ift_src_if;
  logic        valid;
  logic        ready;
  logic [63:0] source_value;
  logic [1:0]  source_size;
  logic        source_is_float;
  logic [1:0]  dest_size;
  logic        dest_is_float;
  logic        saturate;

  modport source (output valid, source_value, source_size, source_is_float,
                  dest_size, dest_is_float, saturate, input ready);
  modport sink   (input valid, source_value, source_size, source_is_float,
                  dest_size, dest_is_float, saturate, output ready);
endinterface

// Result side: one converted value per transaction.
interface ift_dst_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface

`default_nettype wire

// ===== design/ift_unpack.sv =====
// Stage 1: decodes the request, unpacks the source and starts normalizing.
// Depends on ift_pkg.
`default_nettype none

module ift_unpack (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     source_value,
  input  logic [1:0]      source_size,
  input  logic            source_is_float,
  input  logic [1:0]      dest_size,
  input  logic            dest_is_float,
  output logic            out_valid,
  output ift_pkg::stage_t out_st
);
  import ift_pkg::*;

  logic [63:0] raw;
  mode_t       mode;
  stage_t      st;

  // Pick the operation, unpack the source and take the coarse shift steps.
  always_comb begin
    raw = source_value & size_mask(source_size);
    if (dest_size == SIZE_B64) begin
      if (dest_is_float) begin
        mode = (source_is_float && source_size != SIZE_B32) ? MODE_RAW : MODE_TO_D;
      end else begin
        mode = source_is_float ? MODE_TO_I : MODE_RAW;
      end
    end else if (dest_size == SIZE_B32 && dest_is_float) begin
      mode = (source_is_float && source_size == SIZE_B32) ? MODE_RAW : MODE_TO_S;
    end else begin
      mode = source_is_float ? MODE_TO_I : MODE_RAW;
    end

    st.mode = mode;
    st.dsz  = dest_size;
    st.sign = 1'b0;
    st.cls  = CLS_FIN;
    st.exp  = INT_EXP;
    st.sig  = raw;
    if (mode == MODE_RAW) begin
      st.sig = raw & size_mask(dest_size);
    end else if (!source_is_float) begin
      if (raw == 64'd0) st.cls = CLS_ZERO;
    end else if (source_size == SIZE_B32) begin
      st.sign = raw[31];
      st.sig  = {raw[30:23] != 8'd0, raw[22:0], 40'd0};
      st.exp  = (raw[30:23] == 8'd0) ? S_EMIN : $signed({5'd0, raw[30:23]}) - S_BIAS;
      if (raw[30:23] == 8'hFF) begin
        st.cls = (raw[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
      end else if (raw[30:0] == 31'd0) begin
        st.cls = CLS_ZERO;
      end
    end else begin
      // Double subnormals lie far below every result they could give.
      st.sign = raw[63];
      st.sig  = {1'b1, raw[51:0], 11'd0};
      st.exp  = $signed({2'd0, raw[62:52]}) - D_BIAS;
      if (raw[62:52] == 11'h7FF) begin
        st.cls = (raw[51:0] != 52'd0) ? CLS_NAN : CLS_INF;
      end else if (raw[62:52] == 11'd0) begin
        st.cls = CLS_ZERO;
      end
    end

    if (st.cls == CLS_FIN && mode != MODE_RAW) begin
      if (st.sig[63:32] == 32'd0) begin
        st.sig = st.sig << 32;
        st.exp = st.exp - 13'sd32;
      end
      if (st.sig[63:48] == 16'd0) begin
        st.sig = st.sig << 16;
        st.exp = st.exp - 13'sd16;
      end
      if (st.sig[63:56] == 8'd0) begin
        st.sig = st.sig << 8;
        st.exp = st.exp - 13'sd8;
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_st <= st;
    end
  end

endmodule

`default_nettype wire

// ===== design/ift_norm.sv =====
// Stage 2: finishes normalizing the significand of a finite value.
// Depends on ift_pkg.
`default_nettype none

module ift_norm (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ift_pkg::stage_t in_st,
  output logic            out_valid,
  output ift_pkg::stage_t out_st
);
  import ift_pkg::*;

  stage_t st;

  // Fine shift steps; after them the leading one sits in the top bit.
  always_comb begin
    st = in_st;
    if (in_st.cls == CLS_FIN && in_st.mode != MODE_RAW) begin
      if (st.sig[63:60] == 4'd0) begin
        st.sig = st.sig << 4;
        st.exp = st.exp - 13'sd4;
      end
      if (st.sig[63:62] == 2'd0) begin
        st.sig = st.sig << 2;
        st.exp = st.exp - 13'sd2;
      end
      if (!st.sig[63]) begin
        st.sig = st.sig << 1;
        st.exp = st.exp - 13'sd1;
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_st <= st;
    end
  end

endmodule

`default_nettype wire

// ===== design/ift_align.sv =====
// Stage 3: denormalizes single results and rounds float sources bound for narrow integers to single.
// Depends on ift_pkg.
`default_nettype none

module ift_align (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ift_pkg::stage_t in_st,
  output logic            out_valid,
  output ift_pkg::stage_t out_st
);
  import ift_pkg::*;

  stage_t                  st;
  logic signed [EXP_W-1:0] sh;
  logic [5:0]              shamt;
  logic                    lost;
  logic                    inc;
  logic [24:0]             sum24;

  always_comb begin
    st    = in_st;
    sh    = S_EMIN - in_st.exp;
    shamt = sh[5:0];
    lost  = |(in_st.sig & ~(64'hFFFF_FFFF_FFFF_FFFF << shamt));
    inc   = in_st.sig[39] & ((|in_st.sig[38:0]) | in_st.sig[40]);
    sum24 = {1'b0, in_st.sig[63:40]} + {24'd0, inc};
    case (in_st.mode)
      // Below the single normal range: shift right, keep a sticky bit.
      MODE_TO_S: begin
        if (in_st.cls == CLS_FIN && in_st.exp < S_EMIN) begin
          if (sh > 13'sd63) begin
            st.sig = {63'd0, |in_st.sig};
          end else begin
            st.sig = (in_st.sig >> shamt) | {63'd0, lost};
          end
          st.exp = S_EMIN;
        end
      end
      // Narrow destinations read the value as single first: round to 24 bits.
      MODE_TO_I: begin
        if (in_st.cls == CLS_FIN && in_st.dsz != SIZE_B64) begin
          if (sum24[24]) begin
            st.sig = {1'b1, 63'd0};
            st.exp = in_st.exp + 13'sd1;
          end else begin
            st.sig = {sum24[23:0], 40'd0};
          end
        end
      end
      default: begin
        st = in_st;
      end
    endcase
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_st <= st;
    end
  end

endmodule

`default_nettype wire

// ===== design/ift_pack.sv =====
// Stage 4: rounds and packs float results, truncates and clamps integers.
// Depends on ift_pkg. Holds the output register.
`default_nettype none

module ift_pack (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ift_pkg::stage_t in_st,
  output logic            out_valid,
  output logic [63:0]     result
);
  import ift_pkg::*;

  logic [63:0]             res;
  logic                    s_inc;
  logic [24:0]             s_mr;
  logic [7:0]              s_base;
  logic [30:0]             s_bits;
  logic                    d_inc;
  logic [53:0]             d_mr;
  logic [10:0]             d_base;
  logic [62:0]             d_bits;
  logic [63:0]             imax;
  logic signed [EXP_W-1:0] ilim;

  always_comb begin
    // Single: round to nearest even, carry runs into the exponent field.
    s_inc  = in_st.sig[39] & ((|in_st.sig[38:0]) | in_st.sig[40]);
    s_mr   = {1'b0, in_st.sig[63:40]} + {24'd0, s_inc};
    s_base = 8'(in_st.exp + 13'sd126);
    s_bits = {s_base, 23'd0} + {6'd0, s_mr};
    // Double: same scheme at 53 bits.
    d_inc  = in_st.sig[10] & ((|in_st.sig[9:0]) | in_st.sig[11]);
    d_mr   = {1'b0, in_st.sig[63:11]} + {53'd0, d_inc};
    d_base = 11'(in_st.exp + 13'sd1022);
    d_bits = {d_base, 52'd0} + {9'd0, d_mr};
    imax   = size_mask(in_st.dsz);
    case (in_st.dsz)
      SIZE_B8:  ilim = 13'sd8;
      SIZE_B16: ilim = 13'sd16;
      SIZE_B32: ilim = 13'sd32;
      default:  ilim = 13'sd64;
    endcase

    case (in_st.mode)
      MODE_RAW: res = in_st.sig;
      MODE_TO_S: begin
        case (in_st.cls)
          CLS_ZERO: res = {32'd0, in_st.sign, 31'd0};
          CLS_INF:  res = {32'd0, in_st.sign, 8'hFF, 23'd0};
          CLS_NAN:  res = {32'd0, in_st.sign, 8'hFF, 1'b1, in_st.sig[61:40]};
          default: begin
            if (in_st.exp > S_EMAX) res = {32'd0, in_st.sign, 8'hFF, 23'd0};
            else                    res = {32'd0, in_st.sign, s_bits};
          end
        endcase
      end
      MODE_TO_D: begin
        case (in_st.cls)
          CLS_ZERO: res = {in_st.sign, 63'd0};
          CLS_INF:  res = {in_st.sign, 11'h7FF, 52'd0};
          CLS_NAN:  res = {in_st.sign, 11'h7FF, 1'b1, in_st.sig[61:40], 29'd0};
          default:  res = {in_st.sign, d_bits};
        endcase
      end
      // Truncate toward zero; NaN and negatives give zero, large values clamp.
      MODE_TO_I: begin
        if (in_st.cls == CLS_NAN || in_st.cls == CLS_ZERO || in_st.sign) begin
          res = 64'd0;
        end else if (in_st.cls == CLS_INF || in_st.exp >= ilim) begin
          res = imax;
        end else if (in_st.exp < 13'sd0) begin
          res = 64'd0;
        end else begin
          res = in_st.sig >> (~in_st.exp[5:0]);
        end
      end
      default: res = 64'd0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/int_float_type_converter.sv =====
// Top level of the unsigned integer / IEEE float conversion unit.
// Depends on ift_pkg, ift_if, ift_unpack, ift_norm, ift_align, ift_pack
// and assert_macros.svh.
//
//   Channel  Direction  Carries
//   src      in         source_value, source_size, source_is_float,
//                       dest_size, dest_is_float, saturate
//   dst      out        result_value
//
// Four register stages: unpack, normalize, align, pack; the last one is the
// output register. One transaction enters per cycle while the pipe advances.
// The whole pipe advances whenever the output register is empty or taken,
// so a stall at dst freezes every stage and loses nothing.
// Reset (rst, synchronous) clears the valid bits of all stages.
`default_nettype none
`include "assert_macros.svh"

module int_float_type_converter (
  input  logic      clk,
  input  logic      rst,
  ift_src_if.sink   src,
  ift_dst_if.source dst
);
  import ift_pkg::*;

  logic   en;
  logic   v1;
  logic   v2;
  logic   v3;
  stage_t s1;
  stage_t s2;
  stage_t s3;

  // Shared advance for all stages.
  assign en        = !dst.valid || dst.ready;
  assign src.ready = en;

  ift_unpack u_unpack (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (src.valid),
    .source_value    (src.source_value),
    .source_size     (src.source_size),
    .source_is_float (src.source_is_float),
    .dest_size       (src.dest_size),
    .dest_is_float   (src.dest_is_float),
    .out_valid       (v1),
    .out_st          (s1)
  );

  ift_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in_st     (s1),
    .out_valid (v2),
    .out_st    (s2)
  );

  ift_align u_align (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_st     (s2),
    .out_valid (v3),
    .out_st    (s3)
  );

  ift_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_st     (s3),
    .out_valid (dst.valid),
    .result    (dst.result_value)
  );

  // A transaction taken at the input sits in stage 1 on the next cycle.
  `ASSERT_CLK(a_enter, src.valid && src.ready |=> v1, "accepted transaction lost")
  // A finite value leaving normalization has its leading one at the top.
  `ASSERT_NEVER(a_norm, v2 && s2.cls == CLS_FIN && s2.mode != MODE_RAW && !s2.sig[63],
                "significand not normalized")
  // The last stage always reaches the output when the pipe advances.
  `ASSERT_CLK(a_advance, v3 && en |=> dst.valid, "result dropped at output")
  // Single results are zero-extended.
  `ASSERT_CLK(a_single_upper, v3 && en && s3.mode == MODE_TO_S |=> dst.result_value[63:32] == 32'd0,
              "single result has upper bits set")

endmodule

`default_nettype wire
